// File: hdl/sl1_pkg.sv
// Shared types, constants and helper functions for the smooth L1 loss unit.
// Used by every module under hdl/; depends on nothing else.
`default_nettype none

package sl1_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int GRAD_W     = (DATA_W < 32) ? DATA_W : 32;
  localparam int LOSS_W     = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [63:0] ACC_MAX   = {64{1'b1}} >> (64 - ACC_W);
  localparam logic [63:0] LOSS_MAX  = {1'b0, {63{1'b1}}};
  localparam logic [63:0] GRAD_PMAX = (64'd1 << (GRAD_W - 1)) - 64'd1;
  localparam logic [63:0] GRAD_NMAX = 64'd1 << (GRAD_W - 1);
  localparam logic [63:0] ONE_Q     = 64'd1 << FRAC_BITS;

  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_BWD = 1'b1;
  localparam logic RES_LOSS = 1'b0;
  localparam logic RES_GRAD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA_SQ       = 3'd0,
    REG_INV_SIGMA_SQ   = 3'd1,
    REG_INV_BATCH      = 3'd2,
    REG_GRAD_SCALE     = 3'd3,
    REG_INSIDE_ON      = 3'd4,
    REG_OUTSIDE_ON     = 3'd5,
    REG_GRAD_PRED_ON   = 3'd6,
    REG_GRAD_TARGET_ON = 3'd7
  } sl1_reg_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] prediction;
    logic signed [31:0] target;
    logic        [31:0] inside_weight;
    logic        [31:0] outside_weight;
    logic               last;
  } sl1_in_t;

  typedef struct packed {
    logic               result_kind;
    logic [LOSS_W-1:0]  loss;
    logic signed [31:0] grad_pred;
    logic signed [31:0] grad_target;
    logic               saturated;
  } sl1_out_t;

  // Queue word: the element after classification.
  typedef struct packed {
    logic        kind;
    logic        last;
    logic        neg;
    logic [32:0] mag;
    logic [31:0] w_in;
    logic [31:0] w_out;
  } sl1_ent_t;

  typedef struct packed {
    logic [31:0] sigma_sq;
    logic [31:0] inv_sigma_sq;
    logic [16:0] inv_batch;
    logic [31:0] grad_scale;
    logic        inside_on;
    logic        outside_on;
    logic        grad_pred_on;
    logic        grad_target_on;
  } sl1_cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [31:0] b;
    logic        sh_extra;
  } sl1_mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] res;
    logic        sat;
  } sl1_mul_rsp_t;

  typedef struct packed {
    logic [31:0] bits;
    logic        sat;
  } sl1_clamp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_BAND,
    S_SQ,
    S_SIG,
    S_WOUT,
    S_ACC,
    S_LOSS,
    S_GSIG,
    S_GSC,
    S_GWIN,
    S_GWOUT,
    S_GOUT,
    S_EMIT
  } sl1_state_t;

  // Clamp a sign and magnitude pair to the signed gradient width.
  function automatic sl1_clamp_t clamp_grad(input logic neg, input logic [63:0] mag);
    sl1_clamp_t r;
    r.sat = neg ? (mag > GRAD_NMAX) : (mag > GRAD_PMAX);
    if (!neg) begin
      r.bits = r.sat ? GRAD_PMAX[31:0] : mag[31:0];
    end else begin
      r.bits = r.sat ? (~GRAD_NMAX[31:0] + 32'd1) : (~mag[31:0] + 32'd1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sl1_front.sv
// Front stage: accepts input words, forms the difference and splits it into sign
// and magnitude. Depends on sl1_pkg.
`default_nettype none

module sl1_front import sl1_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sl1_in_t  in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output sl1_ent_t      q_ent
);

  logic    st_vld_r;
  sl1_in_t st_item_r;
  logic [32:0] d_pt;
  logic [32:0] d_tp;

  assign q_push   = st_vld_r && !q_full;
  assign in_ready = !st_vld_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      st_vld_r <= 1'b1;
    end else if (q_push) begin
      st_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_item_r <= in_data;
    end
  end

  always_comb begin
    d_pt = {st_item_r.prediction[31], st_item_r.prediction}
         - {st_item_r.target[31], st_item_r.target};
    d_tp = {st_item_r.target[31], st_item_r.target}
         - {st_item_r.prediction[31], st_item_r.prediction};
    q_ent.kind  = st_item_r.kind;
    q_ent.last  = st_item_r.last;
    q_ent.neg   = d_pt[32];
    q_ent.mag   = d_pt[32] ? d_tp : d_pt;
    q_ent.w_in  = st_item_r.inside_weight;
    q_ent.w_out = st_item_r.outside_weight;
  end

endmodule

`default_nettype wire

// File: hdl/sl1_fifo.sv
// Short queue of classified elements between the front stage and the back end.
// Depends on sl1_pkg.
`default_nettype none

module sl1_fifo import sl1_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire sl1_ent_t push_ent,
  input  wire logic     pop,
  output sl1_ent_t      pop_ent,
  output logic          full,
  output logic          empty
);

  sl1_ent_t             ent_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r;

  assign full    = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_ent = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + FIFO_CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond its depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + FIFO_CW'(1)))
    else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

// File: hdl/sl1_mul.sv
// Iterative 64x32 multiplier with a truncating right shift and saturation to 64 bits.
// Two 32x32 products per request; it takes a new request only once the last is done. Depends on sl1_pkg.
`default_nettype none

module sl1_mul import sl1_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire sl1_mul_req_t req,
  output sl1_mul_rsp_t      rsp
);

  logic [1:0]  cnt_r;
  logic [31:0] a_hi_r;
  logic [31:0] b_r;
  logic        sh_r;
  logic [63:0] prod_r;
  logic [63:0] lo_r;
  logic [63:0] res_r;
  logic        sat_r;

  logic [31:0] mult_a;
  logic [31:0] mult_b;
  logic [63:0] mult_p;
  logic [95:0] full_p;
  logic [95:0] shifted;

  // The low half of the operand goes in on the start cycle, the high half next.
  assign mult_a  = (cnt_r == 2'd0) ? req.a[31:0] : a_hi_r;
  assign mult_b  = (cnt_r == 2'd0) ? req.b : b_r;
  assign mult_p  = mult_a * mult_b;
  assign full_p  = {32'd0, lo_r} + {prod_r, 32'd0};
  assign shifted = sh_r ? (full_p >> (FRAC_BITS + 1)) : (full_p >> FRAC_BITS);

  assign rsp.busy = (cnt_r != 2'd0);
  assign rsp.done = (cnt_r == 2'd3);
  assign rsp.res  = res_r;
  assign rsp.sat  = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      unique case (cnt_r)
        2'd0: if (req.start) begin
          cnt_r <= 2'd1;
        end
        2'd1: cnt_r <= 2'd2;
        2'd2: cnt_r <= 2'd3;
        2'd3: cnt_r <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_r == 2'd0 && req.start) begin
      a_hi_r <= req.a[63:32];
      b_r    <= req.b;
      sh_r   <= req.sh_extra;
      prod_r <= mult_p;
    end
    if (cnt_r == 2'd1) begin
      lo_r   <= prod_r;
      prod_r <= mult_p;
    end
    if (cnt_r == 2'd2) begin
      sat_r <= |shifted[95:64];
      res_r <= (|shifted[95:64]) ? {64{1'b1}} : shifted[63:0];
    end
  end

endmodule

`default_nettype wire

// File: hdl/sl1_back.sv
// Back end: sequences the multiplies for one element, keeps the loss accumulator
// and holds the result word. Depends on sl1_pkg and sl1_mul.
`default_nettype none

module sl1_back import sl1_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire sl1_cfg_t cfg,
  input  wire logic     q_empty,
  input  wire sl1_ent_t q_ent,
  output logic          q_pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sl1_out_t      out_data
);

  sl1_state_t   state_r;
  sl1_state_t   state_nxt;

  logic [63:0]  m_r;
  logic [63:0]  val_r;
  logic         neg_r;
  logic         kind_r;
  logic         last_r;
  logic [31:0]  w_in_r;
  logic [31:0]  w_out_r;
  logic         vsat_r;
  logic [63:0]  acc_r;
  logic         clip_r;
  sl1_out_t     res_r;
  logic         out_valid_r;
  sl1_out_t     out_data_r;

  sl1_mul_req_t mul_req;
  sl1_mul_rsp_t mul_rsp;
  logic         mul_state;
  logic         emit;
  logic         in_band;
  logic         gneg;
  logic [31:0]  gmag;
  logic [64:0]  acc_sum;
  logic         acc_ovf;
  logic         loss_sat;
  logic         g_sign;
  sl1_clamp_t   cp;
  sl1_clamp_t   ct;
  logic         osat;

  sl1_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_band  = m_r < {32'd0, cfg.inv_sigma_sq};
  assign gneg     = cfg.grad_scale[31];
  assign gmag     = gneg ? (~cfg.grad_scale + 32'd1) : cfg.grad_scale;
  assign acc_sum  = {1'b0, acc_r} + {1'b0, val_r};
  assign acc_ovf  = acc_sum > {1'b0, ACC_MAX};
  assign loss_sat = mul_rsp.sat || (mul_rsp.res > LOSS_MAX);

  // A zero gradient carries no sign on either output.
  assign g_sign = (neg_r != gneg) && (val_r != '0);
  assign cp     = clamp_grad(g_sign, val_r);
  assign ct     = clamp_grad(!g_sign && (val_r != '0), val_r);
  assign osat   = (cfg.grad_pred_on && cp.sat) || (cfg.grad_target_on && ct.sat)
               || ((cfg.grad_pred_on || cfg.grad_target_on) && vsat_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) begin
        state_nxt = cfg.inside_on ? S_WIN : S_BAND;
      end
      S_WIN: if (mul_rsp.done) begin
        state_nxt = S_BAND;
      end
      S_BAND: begin
        if (kind_r == KIND_FWD) begin
          if (in_band) begin
            state_nxt = S_SQ;
          end else begin
            state_nxt = cfg.outside_on ? S_WOUT : S_ACC;
          end
        end else begin
          state_nxt = in_band ? S_GSIG : S_GSC;
        end
      end
      S_SQ: if (mul_rsp.done) begin
        state_nxt = S_SIG;
      end
      S_SIG: if (mul_rsp.done) begin
        state_nxt = cfg.outside_on ? S_WOUT : S_ACC;
      end
      S_WOUT: if (mul_rsp.done) begin
        state_nxt = S_ACC;
      end
      S_ACC: state_nxt = last_r ? S_LOSS : S_IDLE;
      S_LOSS: if (mul_rsp.done) begin
        state_nxt = S_EMIT;
      end
      S_GSIG: if (mul_rsp.done) begin
        state_nxt = S_GSC;
      end
      S_GSC: if (mul_rsp.done) begin
        if (cfg.inside_on) begin
          state_nxt = S_GWIN;
        end else begin
          state_nxt = cfg.outside_on ? S_GWOUT : S_GOUT;
        end
      end
      S_GWIN: if (mul_rsp.done) begin
        state_nxt = cfg.outside_on ? S_GWOUT : S_GOUT;
      end
      S_GWOUT: if (mul_rsp.done) begin
        state_nxt = S_GOUT;
      end
      S_GOUT: state_nxt = S_EMIT;
      S_EMIT: if (!out_valid_r || out_ready) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop, multiplier operands, result load.
  always_comb begin
    q_pop            = (state_r == S_IDLE) && !q_empty;
    emit             = (state_r == S_EMIT) && (!out_valid_r || out_ready);
    mul_state        = 1'b1;
    mul_req.a        = val_r;
    mul_req.b        = w_out_r;
    mul_req.sh_extra = 1'b0;
    unique case (state_r)
      S_WIN: begin
        mul_req.a = m_r;
        mul_req.b = w_in_r;
      end
      S_SQ: begin
        mul_req.a = m_r;
        mul_req.b = m_r[31:0];
      end
      S_SIG: begin
        mul_req.b        = cfg.sigma_sq;
        mul_req.sh_extra = 1'b1;
      end
      S_WOUT, S_GWOUT: mul_req.b = w_out_r;
      S_LOSS: begin
        mul_req.a = acc_r;
        mul_req.b = {15'd0, cfg.inv_batch};
      end
      S_GSIG: begin
        mul_req.a = m_r;
        mul_req.b = cfg.sigma_sq;
      end
      S_GSC:  mul_req.b = gmag;
      S_GWIN: mul_req.b = w_in_r;
      default: mul_state = 1'b0;
    endcase
    mul_req.start = mul_state && !mul_rsp.busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      clip_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_ACC) begin
        acc_r  <= acc_ovf ? ACC_MAX : acc_sum[63:0];
        clip_r <= clip_r || vsat_r || acc_ovf;
      end else if (state_r == S_LOSS && mul_rsp.done) begin
        acc_r  <= '0;
        clip_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_r     <= {31'd0, q_ent.mag};
      neg_r   <= q_ent.neg;
      kind_r  <= q_ent.kind;
      last_r  <= q_ent.last;
      w_in_r  <= q_ent.w_in;
      w_out_r <= q_ent.w_out;
      vsat_r  <= 1'b0;
    end
    if (state_r == S_WIN && mul_rsp.done) begin
      m_r    <= mul_rsp.res;
      vsat_r <= vsat_r || mul_rsp.sat;
    end
    // Outside the band; an in-band element overwrites this with a product later.
    if (state_r == S_BAND) begin
      if (kind_r == KIND_FWD) begin
        val_r <= m_r - {33'd0, cfg.inv_sigma_sq[31:1]};
      end else begin
        val_r <= (m_r != '0) ? ONE_Q : '0;
      end
    end
    if (mul_rsp.done && (state_r == S_SQ || state_r == S_SIG || state_r == S_WOUT
        || state_r == S_GSIG || state_r == S_GSC || state_r == S_GWIN
        || state_r == S_GWOUT)) begin
      val_r  <= mul_rsp.res;
      vsat_r <= vsat_r || mul_rsp.sat;
    end
    if (state_r == S_LOSS && mul_rsp.done) begin
      res_r.result_kind <= RES_LOSS;
      res_r.loss        <= loss_sat ? LOSS_MAX[LOSS_W-1:0] : mul_rsp.res[LOSS_W-1:0];
      res_r.grad_pred   <= '0;
      res_r.grad_target <= '0;
      res_r.saturated   <= loss_sat || clip_r;
    end
    if (state_r == S_GOUT) begin
      res_r.result_kind <= RES_GRAD;
      res_r.loss        <= '0;
      res_r.grad_pred   <= cfg.grad_pred_on ? cp.bits : '0;
      res_r.grad_target <= cfg.grad_target_on ? ct.bits : '0;
      res_r.saturated   <= osat;
    end
    if (emit) begin
      out_data_r <= res_r;
    end
  end

  a_mul_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.busy |-> (state_r == S_WIN || state_r == S_SQ || state_r == S_SIG
      || state_r == S_WOUT || state_r == S_LOSS || state_r == S_GSIG
      || state_r == S_GSC || state_r == S_GWIN || state_r == S_GWOUT))
    else $error("multiplier busy outside a multiply step");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOSS && mul_rsp.done) |=> (acc_r == '0 && !clip_r))
    else $error("accumulator not cleared after the batch result");

  a_grad_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.result_kind == RES_GRAD) |-> (out_data_r.loss == '0))
    else $error("gradient word carries a loss value");

endmodule

`default_nettype wire

// File: hdl/smooth_l1_loss_unit.sv
// The back end's shared 64x32 multiplier sets the pace, with up to five multiplies per
// element; the front stage and queue take new elements while the back end works, until full.
// An element passes the front stage register and the queue, then the back-end steps;
// a batch's last forward element adds one more product for the mean.
// Reset: synchronous, active low; clears control, the accumulator and the
// configuration registers to their defaults at once, with no clearing pass.
`default_nettype none

module smooth_l1_loss_unit import sl1_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire sl1_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output sl1_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  sl1_cfg_t cfg_r;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  sl1_ent_t q_in;
  sl1_ent_t q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sigma_sq       <= 32'h0001_0000;
      cfg_r.inv_sigma_sq   <= 32'h0001_0000;
      cfg_r.inv_batch      <= 17'h1_0000;
      cfg_r.grad_scale     <= 32'h0001_0000;
      cfg_r.inside_on      <= 1'b0;
      cfg_r.outside_on     <= 1'b0;
      cfg_r.grad_pred_on   <= 1'b1;
      cfg_r.grad_target_on <= 1'b1;
    end else if (cfg_we) begin
      unique case (sl1_reg_t'(cfg_index))
        REG_SIGMA_SQ:       cfg_r.sigma_sq       <= cfg_wdata;
        REG_INV_SIGMA_SQ:   cfg_r.inv_sigma_sq   <= cfg_wdata;
        REG_INV_BATCH:      cfg_r.inv_batch      <= cfg_wdata[16:0];
        REG_GRAD_SCALE:     cfg_r.grad_scale     <= cfg_wdata;
        REG_INSIDE_ON:      cfg_r.inside_on      <= cfg_wdata[0];
        REG_OUTSIDE_ON:     cfg_r.outside_on     <= cfg_wdata[0];
        REG_GRAD_PRED_ON:   cfg_r.grad_pred_on   <= cfg_wdata[0];
        REG_GRAD_TARGET_ON: cfg_r.grad_target_on <= cfg_wdata[0];
      endcase
    end
  end

  sl1_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ent    (q_in)
  );

  sl1_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_in),
    .pop      (q_pop),
    .pop_ent  (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  sl1_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_ent     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
